// ===== rtl/nhst_pkg.sv =====
package nhst_pkg;

	localparam int CMD_W    = 2;
	localparam int NODE_W   = 4;
	localparam int CHAR_W   = 8;
	localparam int STATUS_W = 3;
	localparam int AGE_W    = 8;
	localparam int DROP_W   = 4;
	localparam int IN_W     = 16;
	localparam int OUT_W    = 8;
	localparam int APB_AW   = 3;
	localparam int APB_DW   = 32;

	localparam logic [CMD_W-1:0] CMD_TICK     = 2'd0;
	localparam logic [CMD_W-1:0] CMD_RESPONSE = 2'd1;

	localparam logic [STATUS_W-1:0] ST_OFFLINE = 3'd0;
	localparam logic [STATUS_W-1:0] ST_ONLINE  = 3'd1;
	localparam logic [STATUS_W-1:0] ST_EXAM    = 3'd2;
	localparam logic [STATUS_W-1:0] ST_STARTED = 3'd3;
	localparam logic [STATUS_W-1:0] ST_PAUSED  = 3'd4;

	localparam logic [CHAR_W-1:0] CHAR_ACK   = 8'h41;
	localparam logic [CHAR_W-1:0] CHAR_EXAM  = 8'h45;
	localparam logic [CHAR_W-1:0] CHAR_START = 8'h53;
	localparam logic [CHAR_W-1:0] CHAR_PAUSE = 8'h50;

	localparam logic [AGE_W-1:0]  MAX_SILENT_RESET = 8'd10;
	localparam logic [DROP_W-1:0] DROP_MAX         = 4'd15;

	// register index of max_silent_ticks, taken from paddr[2]
	localparam logic REG_MAX_SILENT = 1'b0;

	typedef struct packed {
		logic [STATUS_W-1:0] status;
		logic [AGE_W-1:0]    age;
	} entry_t;

	typedef enum logic [3:0] {
		SEQ_IDLE = 4'b0001,
		SEQ_WALK = 4'b0010,
		SEQ_LOOK = 4'b0100,
		SEQ_EMIT = 4'b1000
	} seq_state_t;

endpackage

// ===== rtl/node_heartbeat_status_table.sv =====
// Response and read items: an accepted item passes through lookup, then emit, to m_tvalid.
// Tick items: the walk reads and writes back one slot per cycle
// through the single-port-read table memory, then the addressed slot is read again.
// An item is accepted only in idle, once the previous one has been emitted; a new item
// is taken while a finished result waits, and the next emit stalls until it is taken.
// Reset clears slot valid bits (offline, age zero) and sets max_silent_ticks to 10.
module node_heartbeat_status_table #(
	parameter int NUM_SLOTS = 16
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          s_tvalid,
	output logic                          s_tready,
	// [1:0] command, [5:2] node_id, [13:6] response_char
	input  logic [nhst_pkg::IN_W-1:0]     s_tdata,
	output logic                          m_tvalid,
	input  logic                          m_tready,
	// [2:0] node_status, [6:3] dropped_count
	output logic [nhst_pkg::OUT_W-1:0]    m_tdata,
	input  logic                          psel,
	input  logic                          penable,
	input  logic                          pwrite,
	input  logic [nhst_pkg::APB_AW-1:0]   paddr,
	input  logic [nhst_pkg::APB_DW-1:0]   pwdata,
	output logic [nhst_pkg::APB_DW-1:0]   prdata,
	output logic                          pready
);
	import nhst_pkg::*;

	localparam int SLOT_W = (NUM_SLOTS > 1) ? $clog2(NUM_SLOTS) : 1;
	localparam logic [SLOT_W-1:0] LAST_SLOT = SLOT_W'(NUM_SLOTS - 1);
	localparam logic [SLOT_W-1:0] FIRST_SLOT = SLOT_W'(1);

	seq_state_t state_q, state_d;

	logic [CMD_W-1:0]    cmd_q;
	logic [NODE_W-1:0]   node_q;
	logic [CHAR_W-1:0]   char_q;
	logic [SLOT_W-1:0]   idx_q, idx_d;
	logic [DROP_W-1:0]   drop_q, drop_d;
	logic [STATUS_W-1:0] res_status_q, res_status_d;
	logic [AGE_W-1:0]    max_silent_q;

	logic                m_tvalid_q;
	logic [OUT_W-1:0]    out_data_q;
	logic                out_load;

	entry_t              mem_q [NUM_SLOTS];
	logic [NUM_SLOTS-1:0] valid_q;
	entry_t              rd_data_s1;
	logic                rd_vld_s1;
	logic                byp_s1;
	entry_t              byp_data_s1;

	logic                rd_en;
	logic [SLOT_W-1:0]   rd_addr;
	logic                wr_en;
	logic [SLOT_W-1:0]   wr_addr;
	entry_t              wr_data;
	entry_t              cur;

	logic                in_take;
	logic [CMD_W-1:0]    in_cmd;
	logic [NODE_W-1:0]   in_node;
	logic                node_ok;
	logic [SLOT_W-1:0]   node_slot;
	logic                cfg_wr;

	assign in_cmd  = s_tdata[CMD_W-1:0];
	assign in_node = s_tdata[CMD_W+NODE_W-1:CMD_W];
	assign s_tready = (state_q == SEQ_IDLE);
	assign in_take  = s_tvalid && s_tready;

	assign node_ok   = (32'(node_q) < NUM_SLOTS);
	assign node_slot = SLOT_W'(node_q);

	assign cur = byp_s1 ? byp_data_s1 : (rd_vld_s1 ? rd_data_s1 : entry_t'('0));

	always_comb begin
		state_d      = state_q;
		idx_d        = idx_q;
		drop_d       = drop_q;
		res_status_d = res_status_q;
		rd_en        = 1'b0;
		rd_addr      = '0;
		wr_en        = 1'b0;
		wr_addr      = '0;
		wr_data      = cur;
		out_load     = 1'b0;
		unique case (state_q)
			SEQ_IDLE: begin
				if (in_take) begin
					drop_d = '0;
					rd_en  = 1'b1;
					if (in_cmd == CMD_TICK) begin
						rd_addr = FIRST_SLOT;
						idx_d   = FIRST_SLOT;
						state_d = SEQ_WALK;
					end else begin
						rd_addr = SLOT_W'(in_node);
						state_d = SEQ_LOOK;
					end
				end
			end
			SEQ_WALK: begin
				wr_addr = idx_q;
				if (cur.status == ST_ONLINE) begin
					wr_en = 1'b1;
					if (cur.age == max_silent_q) begin
						wr_data.status = ST_OFFLINE;
						if (drop_q != DROP_MAX) begin
							drop_d = drop_q + 1'b1;
						end
					end else begin
						wr_data.age = cur.age + 1'b1;
					end
				end
				rd_en = 1'b1;
				if (idx_q == LAST_SLOT) begin
					rd_addr = node_slot;
					state_d = SEQ_LOOK;
				end else begin
					rd_addr = SLOT_W'(idx_q + 1'b1);
					idx_d   = SLOT_W'(idx_q + 1'b1);
				end
			end
			SEQ_LOOK: begin
				wr_addr = node_slot;
				if (cmd_q == CMD_RESPONSE && node_ok) begin
					case (char_q)
						CHAR_ACK: begin
							wr_en          = 1'b1;
							wr_data.status = ST_ONLINE;
							wr_data.age    = '0;
						end
						CHAR_EXAM: begin
							wr_en          = 1'b1;
							wr_data.status = ST_EXAM;
						end
						CHAR_START: begin
							wr_en          = 1'b1;
							wr_data.status = ST_STARTED;
						end
						CHAR_PAUSE: begin
							wr_en          = 1'b1;
							wr_data.status = ST_PAUSED;
						end
						default: begin
							wr_en = 1'b0;
						end
					endcase
				end
				res_status_d = node_ok ? wr_data.status : ST_OFFLINE;
				state_d      = SEQ_EMIT;
			end
			SEQ_EMIT: begin
				if (!m_tvalid_q || m_tready) begin
					out_load = 1'b1;
					state_d  = SEQ_IDLE;
				end
			end
			default: begin
				state_d = SEQ_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= SEQ_IDLE;
			m_tvalid_q <= 1'b0;
			valid_q    <= '0;
		end else begin
			state_q <= state_d;
			if (out_load) begin
				m_tvalid_q <= 1'b1;
			end else if (m_tready) begin
				m_tvalid_q <= 1'b0;
			end
			if (wr_en) begin
				valid_q[wr_addr] <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (in_take) begin
			cmd_q  <= in_cmd;
			node_q <= in_node;
			char_q <= s_tdata[CMD_W+NODE_W+CHAR_W-1:CMD_W+NODE_W];
		end
		idx_q        <= idx_d;
		drop_q       <= drop_d;
		res_status_q <= res_status_d;
		if (out_load) begin
			out_data_q <= {1'b0, drop_q, res_status_q};
		end
	end

	// table memory: one write port, one registered read port, write-to-read bypass
	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wr_addr] <= wr_data;
		end
	end

	always_ff @(posedge clk) begin
		if (rd_en) begin
			rd_data_s1  <= mem_q[rd_addr];
			rd_vld_s1   <= valid_q[rd_addr];
			byp_s1      <= wr_en && (wr_addr == rd_addr);
			byp_data_s1 <= wr_data;
		end
	end

	// configuration
	assign cfg_wr = psel && penable && pwrite && pready;
	assign pready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			max_silent_q <= MAX_SILENT_RESET;
		end else if (cfg_wr && paddr[2] == REG_MAX_SILENT) begin
			max_silent_q <= pwdata[AGE_W-1:0];
		end
	end

	assign prdata = (paddr[2] == REG_MAX_SILENT) ? APB_DW'(max_silent_q) : '0;

	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = out_data_q;

	a_wr_state: assert property (@(posedge clk) disable iff (!arst_n)
		wr_en |-> (state_q == SEQ_WALK || state_q == SEQ_LOOK))
		else $error("table written outside walk or lookup");

	a_master_kept: assert property (@(posedge clk) disable iff (!arst_n)
		(wr_en && state_q == SEQ_WALK) |-> (wr_addr != '0))
		else $error("tick walk wrote the master slot");

	a_look_emit: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == SEQ_LOOK) |=> (state_q == SEQ_EMIT))
		else $error("lookup not followed by emit");

	a_drop_tick: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == SEQ_EMIT && drop_q != '0) |-> (cmd_q == CMD_TICK))
		else $error("drop count set for a non-tick item");

	a_in_idle: assert property (@(posedge clk) disable iff (!arst_n)
		(in_take && in_cmd == CMD_TICK) |=> (state_q == SEQ_WALK && idx_q == FIRST_SLOT))
		else $error("tick walk did not start at slot one");

endmodule

// ===== tb/nhst_checker.sv =====
module nhst_checker #(
	parameter int NUM_SLOTS = 16
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        s_tvalid,
	input  logic                        s_tready,
	input  logic [nhst_pkg::IN_W-1:0]   s_tdata,
	input  logic                        m_tvalid,
	input  logic                        m_tready,
	input  logic [nhst_pkg::OUT_W-1:0]  m_tdata,
	input  logic                        psel,
	input  logic                        penable,
	input  logic                        pwrite,
	input  logic [nhst_pkg::APB_AW-1:0] paddr,
	input  logic [nhst_pkg::APB_DW-1:0] pwdata,
	input  logic                        pready,
	output int                          mismatches,
	output int                          pending,
	output int                          ticks_seen,
	output int                          drops_seen
);
	timeunit 1ns;
	timeprecision 1ps;

	import nhst_pkg::*;

	typedef struct packed {
		logic [STATUS_W-1:0] status;
		logic [DROP_W-1:0]   dropped;
	} slot_report_t;

	logic [STATUS_W-1:0] status_tbl [NUM_SLOTS];
	logic [AGE_W-1:0]    age_tbl [NUM_SLOTS];
	logic [AGE_W-1:0]    silent_limit;
	slot_report_t        report_q [$];
	int                  mism_count = 0;
	int                  tick_count = 0;
	int                  drop_count = 0;

	initial begin
		mismatches = 0;
		pending    = 0;
		ticks_seen = 0;
		drops_seen = 0;
	end

	task automatic predict_item(input logic [IN_W-1:0] word);
		logic [CMD_W-1:0]  cmd;
		logic [NODE_W-1:0] id;
		logic [CHAR_W-1:0] code;
		slot_report_t      rep;
		cmd         = word[1:0];
		id          = word[5:2];
		code        = word[13:6];
		rep.dropped = '0;
		if (cmd == CMD_TICK) begin
			tick_count++;
			// slot 0 is the master and never ages
			for (int i = 1; i < NUM_SLOTS; i++) begin
				if (status_tbl[i] == ST_ONLINE) begin
					if (age_tbl[i] == silent_limit) begin
						status_tbl[i] = ST_OFFLINE;
						drop_count++;
						if (rep.dropped < DROP_MAX)
							rep.dropped = rep.dropped + 1'b1;
					end else begin
						age_tbl[i] = age_tbl[i] + 1'b1;
					end
				end
			end
		end else if (cmd == CMD_RESPONSE && id < NUM_SLOTS) begin
			case (code)
				CHAR_ACK: begin
					status_tbl[id] = ST_ONLINE;
					age_tbl[id]    = '0;
				end
				CHAR_EXAM:  status_tbl[id] = ST_EXAM;
				CHAR_START: status_tbl[id] = ST_STARTED;
				CHAR_PAUSE: status_tbl[id] = ST_PAUSED;
				default: ;
			endcase
		end
		rep.status = (id < NUM_SLOTS) ? status_tbl[id] : ST_OFFLINE;
		report_q.push_back(rep);
	endtask

	task automatic check_result(input logic [OUT_W-1:0] word);
		slot_report_t        want;
		logic [STATUS_W-1:0] got_status;
		logic [DROP_W-1:0]   got_drop;
		got_status = word[2:0];
		got_drop   = word[6:3];
		if (report_q.size() == 0) begin
			if (mism_count < 10)
				$display("%0t: unexpected item status=%0d dropped=%0d",
					$realtime, got_status, got_drop);
			mism_count++;
		end else begin
			want = report_q.pop_front();
			if (want.status != got_status || want.dropped != got_drop) begin
				if (mism_count < 10)
					$display("%0t: mismatch status exp=%0d got=%0d, dropped exp=%0d got=%0d",
						$realtime, want.status, got_status, want.dropped, got_drop);
				mism_count++;
			end
		end
	endtask

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < NUM_SLOTS; i++) begin
				status_tbl[i] = ST_OFFLINE;
				age_tbl[i]    = '0;
			end
			silent_limit = MAX_SILENT_RESET;
			report_q.delete();
			pending <= 0;
		end else begin
			if (m_tvalid && m_tready)
				check_result(m_tdata);
			if (s_tvalid && s_tready)
				predict_item(s_tdata);
			if (psel && penable && pwrite && pready && paddr[2] == REG_MAX_SILENT)
				silent_limit = pwdata[AGE_W-1:0];
			pending    <= report_q.size();
			mismatches <= mism_count;
			ticks_seen <= tick_count;
			drops_seen <= drop_count;
		end
	end

endmodule

// ===== tb/testbench.sv =====
module testbench;
	timeunit 1ns;
	timeprecision 1ps;

	import nhst_pkg::*;

	localparam int NUM_SLOTS    = 16;
	localparam int CYCLE_LIMIT  = 400000;
	localparam int HOLD_CYCLES  = 300;
	localparam int DRAIN_CYCLES = 3 * (NUM_SLOTS + 2);

	localparam logic [CMD_W-1:0] CMD_READ  = 2'd2;
	localparam logic [CMD_W-1:0] CMD_SPARE = 2'd3;

	logic              clk      = 1'b0;
	logic              arst_n   = 1'b0;
	logic              s_tvalid = 1'b0;
	logic [IN_W-1:0]   s_tdata  = '0;
	logic              m_tready = 1'b0;
	logic              psel     = 1'b0;
	logic              penable  = 1'b0;
	logic              pwrite   = 1'b0;
	logic [APB_AW-1:0] paddr    = '0;
	logic [APB_DW-1:0] pwdata   = '0;
	logic              s_tready;
	logic              m_tvalid;
	logic [OUT_W-1:0]  m_tdata;
	logic [APB_DW-1:0] prdata;
	logic              pready;

	int mismatches;
	int pending;
	int ticks_seen;
	int drops_seen;
	int cycle_count    = 0;
	int items_sent     = 0;
	int settings_used  = 0;
	int hold_left      = 0;
	bit hold_done      = 1'b0;
	bit hold_req       = 1'b0;
	bit calm           = 1'b0;

	node_heartbeat_status_table #(.NUM_SLOTS(NUM_SLOTS)) dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.psel     (psel),
		.penable  (penable),
		.pwrite   (pwrite),
		.paddr    (paddr),
		.pwdata   (pwdata),
		.prdata   (prdata),
		.pready   (pready)
	);

	nhst_checker #(.NUM_SLOTS(NUM_SLOTS)) chk (
		.clk        (clk),
		.arst_n     (arst_n),
		.s_tvalid   (s_tvalid),
		.s_tready   (s_tready),
		.s_tdata    (s_tdata),
		.m_tvalid   (m_tvalid),
		.m_tready   (m_tready),
		.m_tdata    (m_tdata),
		.psel       (psel),
		.penable    (penable),
		.pwrite     (pwrite),
		.paddr      (paddr),
		.pwdata     (pwdata),
		.pready     (pready),
		.mismatches (mismatches),
		.pending    (pending),
		.ticks_seen (ticks_seen),
		.drops_seen (drops_seen)
	);

	initial begin
		forever #6 clk = ~clk;
	end

	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count == CYCLE_LIMIT) begin
			$display("timeout after %0d cycles, %0d items outstanding", cycle_count, pending);
			$display("** node_heartbeat_status_table: FAILED **");
			$finish;
		end
	end

	// receiver: random back-pressure, one long hold-off on request
	always @(posedge clk) begin
		if (hold_req && !hold_done) begin
			hold_done = 1'b1;
			hold_left = HOLD_CYCLES;
		end
		if (hold_left > 0) begin
			hold_left = hold_left - 1;
			m_tready <= 1'b0;
		end else begin
			m_tready <= calm || ($urandom_range(99) >= 19);
		end
	end

	function automatic logic [IN_W-1:0] make_word(input logic [CMD_W-1:0] cmd,
			input logic [NODE_W-1:0] id, input logic [CHAR_W-1:0] code);
		return {2'b00, code, id, cmd};
	endfunction

	function automatic logic [CHAR_W-1:0] random_code();
		case ($urandom_range(9))
			0, 1, 2, 3, 4: return CHAR_ACK;
			5:             return CHAR_EXAM;
			6:             return CHAR_START;
			7:             return CHAR_PAUSE;
			default:       return CHAR_W'($urandom);
		endcase
	endfunction

	function automatic logic [IN_W-1:0] random_word(input int tick_pct, input int resp_pct);
		int               r;
		logic [CMD_W-1:0] cmd;
		r = $urandom_range(99);
		if (r < tick_pct)
			cmd = CMD_TICK;
		else if (r < tick_pct + resp_pct)
			cmd = CMD_RESPONSE;
		else if ($urandom_range(3) == 0)
			cmd = CMD_SPARE;
		else
			cmd = CMD_READ;
		return make_word(cmd, NODE_W'($urandom_range(NUM_SLOTS - 1)), random_code());
	endfunction

	task automatic send_word(input logic [IN_W-1:0] word);
		while (!calm && $urandom_range(99) < 19) begin
			s_tvalid <= 1'b0;
			@(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata  <= word;
		do @(posedge clk); while (!s_tready);
		items_sent++;
	endtask

	task automatic settle();
		s_tvalid <= 1'b0;
		do @(posedge clk); while (pending != 0);
	endtask

	task automatic write_limit(input logic [AGE_W-1:0] value);
		logic [APB_DW-1:0] word;
		word            = $urandom;
		word[AGE_W-1:0] = value;
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= 1'b1;
		paddr   <= {REG_MAX_SILENT, 2'b00};
		pwdata  <= word;
		@(posedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		psel    <= 1'b0;
		penable <= 1'b0;
		pwrite  <= 1'b0;
		settings_used++;
	endtask

	task automatic run_phase(input logic [AGE_W-1:0] limit, input int count,
			input int tick_pct, input int resp_pct, input bit quiet, input bit squeeze);
		settle();
		write_limit(limit);
		calm = quiet;
		if (squeeze)
			hold_req = 1'b1;
		repeat (count)
			send_word(random_word(tick_pct, resp_pct));
		calm = 1'b0;
	endtask

	initial begin
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// reset limit: every command, every code, master slot, junk codes
		send_word(make_word(CMD_READ, 4'd0, 8'h00));
		send_word(make_word(CMD_SPARE, 4'd15, 8'hFF));
		send_word(make_word(CMD_RESPONSE, 4'd0, CHAR_ACK));
		send_word(make_word(CMD_RESPONSE, 4'd1, CHAR_ACK));
		send_word(make_word(CMD_RESPONSE, 4'd15, CHAR_ACK));
		send_word(make_word(CMD_RESPONSE, 4'd2, CHAR_EXAM));
		send_word(make_word(CMD_RESPONSE, 4'd3, CHAR_START));
		send_word(make_word(CMD_RESPONSE, 4'd4, CHAR_PAUSE));
		send_word(make_word(CMD_RESPONSE, 4'd5, 8'h00));
		send_word(make_word(CMD_RESPONSE, 4'd6, 8'h61));
		send_word(make_word(CMD_TICK, 4'd2, 8'hFF));

		// limit zero, all slots online: one tick drops every slot but the master
		settle();
		write_limit(8'd0);
		for (int i = 1; i < NUM_SLOTS; i++)
			send_word(make_word(CMD_RESPONSE, NODE_W'(i), CHAR_ACK));
		send_word(make_word(CMD_TICK, 4'd15, 8'h00));

		run_phase(8'd0, 150, 30, 50, 1'b0, 1'b1);
		run_phase(8'd255, 150, 25, 55, 1'b0, 1'b0);
		run_phase(8'd3, 200, 35, 45, 1'b1, 1'b0);
		run_phase(8'd90, 150, 50, 40, 1'b0, 1'b0);
		// aged slots sit above the new limit and have to wrap before dropping
		run_phase(8'd2, 300, 85, 5, 1'b0, 1'b0);
		run_phase(AGE_W'($urandom), 150, 35, 45, 1'b0, 1'b0);

		settle();
		repeat (DRAIN_CYCLES) @(posedge clk);

		$display("Sent %0d items under %0d limit settings: %0d ticks, %0d slots timed out.",
			items_sent, settings_used, ticks_seen, drops_seen);
		if (mismatches == 0 && pending == 0) begin
			$display("** node_heartbeat_status_table: PASSED **");
		end else begin
			$display("%0d mismatches, %0d items outstanding", mismatches, pending);
			$display("** node_heartbeat_status_table: FAILED **");
		end
		$finish;
	end

endmodule
